[hdl/hamming_encode_check_core_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the Hamming encode/check core
// Shared property templates, clocked and reset-gated by the caller.
// ---------------------------------------------------------------------------
`ifndef HAMMING_ENCODE_CHECK_CORE_ASSERT_SVH
`define HAMMING_ENCODE_CHECK_CORE_ASSERT_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define HEC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the next cycle.
`define HEC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/hec_pkg.sv]
// ---------------------------------------------------------------------------
// Hamming encode/check package
// Types, constants and helper functions shared by the coder modules.
// ---------------------------------------------------------------------------
package hec_pkg;

    localparam int DATA_BITS = 26;
    localparam int CODE_BITS = 31;
    localparam int POS_BITS  = 5;

    localparam logic [POS_BITS-1:0] DATA_LEN_RESET = 5'd4;
    localparam logic [POS_BITS-1:0] DATA_LEN_MAX   = 5'd26;

    // Commands carried with each input word.
    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_CHECK  = 1'b1;

    // Bit i of a position number selects these codeword bits.
    localparam logic [CODE_BITS-1:0] SYN_MASK_0 = 31'h55555555;
    localparam logic [CODE_BITS-1:0] SYN_MASK_1 = 31'h66666666;
    localparam logic [CODE_BITS-1:0] SYN_MASK_2 = 31'h78787878;
    localparam logic [CODE_BITS-1:0] SYN_MASK_3 = 31'h7F807F80;
    localparam logic [CODE_BITS-1:0] SYN_MASK_4 = 31'h7FFF8000;

    // Derived configuration handed to the coding logic.
    typedef struct packed {
        logic [POS_BITS-1:0]  code_len;
        logic [CODE_BITS-1:0] code_mask;
    } cfg_t;

    // Number of parity bits needed for n data bits.
    function automatic logic [2:0] parity_count(logic [POS_BITS-1:0] n);
        logic [2:0] p;
        if (n <= 5'd1) begin
            p = 3'd2;
        end else if (n <= 5'd4) begin
            p = 3'd3;
        end else if (n <= 5'd11) begin
            p = 3'd4;
        end else begin
            p = 3'd5;
        end
        return p;
    endfunction

    // Largest data length whose codeword fits within the given limit.
    function automatic int max_data_len(int limit);
        int best;
        best = 1;
        for (int k = 1; k <= DATA_BITS; k++) begin
            if (k + int'(parity_count(5'(k))) <= limit) begin
                best = k;
            end
        end
        return best;
    endfunction

    // Syndrome: XOR of the position numbers of all set bits.
    function automatic logic [POS_BITS-1:0] syndrome(logic [CODE_BITS-1:0] w);
        logic [POS_BITS-1:0] s;
        s[0] = ^(w & SYN_MASK_0);
        s[1] = ^(w & SYN_MASK_1);
        s[2] = ^(w & SYN_MASK_2);
        s[3] = ^(w & SYN_MASK_3);
        s[4] = ^(w & SYN_MASK_4);
        return s;
    endfunction

    // Place data bits, in order, at the positions that are not powers of two.
    function automatic logic [CODE_BITS-1:0] scatter(logic [DATA_BITS-1:0] d);
        logic [CODE_BITS-1:0] cw;
        int j;
        cw = '0;
        j  = 0;
        for (int pos = 1; pos <= CODE_BITS; pos++) begin
            if ((pos & (pos - 1)) != 0) begin
                cw[pos-1] = d[j];
                j++;
            end
        end
        return cw;
    endfunction

endpackage

[hdl/hec_cfg.sv]
// ---------------------------------------------------------------------------
// Hamming coder configuration register
// Takes the data length write and holds the code length and code mask.
// ---------------------------------------------------------------------------
module hec_cfg #(
    parameter int MAX_CODE_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic [hec_pkg::POS_BITS-1:0]  cfg_data,
    output hec_pkg::cfg_t                 cfg
);
    import hec_pkg::*;

    localparam int LIMIT = (MAX_CODE_BITS < CODE_BITS) ? MAX_CODE_BITS : CODE_BITS;
    localparam logic [POS_BITS-1:0] N_LIMIT = POS_BITS'(max_data_len(LIMIT));

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Clamp the requested length and derive the codeword length and mask.
    function automatic cfg_t derive(logic [POS_BITS-1:0] v);
        logic [POS_BITS-1:0] n;
        cfg_t c;
        n = v;
        if (n == 5'd0) begin
            n = 5'd1;
        end else if (n > DATA_LEN_MAX) begin
            n = DATA_LEN_MAX;
        end
        if (n > N_LIMIT) begin
            n = N_LIMIT;
        end
        c.code_len  = n + POS_BITS'(parity_count(n));
        c.code_mask = {CODE_BITS{1'b1}} >> (5'd31 - c.code_len);
        return c;
    endfunction

    // The derived values are worked out from the write data itself, so they
    // are in force from the cycle after the write.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            cfg_next = derive(cfg_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= derive(DATA_LEN_RESET);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/hec_code_unit.sv]
// ---------------------------------------------------------------------------
// Hamming coder datapath
// Encodes a data word or computes the syndrome of a received codeword.
// ---------------------------------------------------------------------------
module hec_code_unit (
    input  logic                           command,
    input  logic [hec_pkg::DATA_BITS-1:0]  data_word,
    input  logic [hec_pkg::CODE_BITS-1:0]  received_word,
    input  hec_pkg::cfg_t                  cfg,
    output logic [hec_pkg::CODE_BITS-1:0]  code_word,
    output logic [hec_pkg::POS_BITS-1:0]   error_position,
    output logic [hec_pkg::POS_BITS-1:0]   code_length
);
    import hec_pkg::*;

    logic [CODE_BITS-1:0] data_placed;
    logic [POS_BITS-1:0]  enc_syn;
    logic [CODE_BITS-1:0] enc_word;
    logic [POS_BITS-1:0]  chk_syn;

    // Encode: data bits beyond the length fall outside the mask. With the
    // parity positions still clear, the syndrome gives the parity bits.
    always_comb begin
        data_placed = scatter(data_word) & cfg.code_mask;
        enc_syn     = syndrome(data_placed);
        enc_word    = data_placed;
        enc_word[0]  = enc_syn[0];
        enc_word[1]  = enc_syn[1];
        enc_word[3]  = enc_syn[2];
        enc_word[7]  = enc_syn[3];
        enc_word[15] = enc_syn[4];
    end

    // Check: syndrome over the positions within the code length.
    assign chk_syn = syndrome(received_word & cfg.code_mask);

    // Select the result for the command.
    always_comb begin
        case (command)
            CMD_ENCODE: begin
                code_word      = enc_word;
                error_position = '0;
            end
            CMD_CHECK: begin
                code_word      = '0;
                error_position = chk_syn;
            end
            default: begin
                code_word      = '0;
                error_position = '0;
            end
        endcase
    end

    assign code_length = cfg.code_len;

endmodule

[hdl/hamming_encode_check_core.sv]
// ---------------------------------------------------------------------------
// Hamming encode/check core
// Even-parity Hamming coder with a programmable data length.
// ---------------------------------------------------------------------------
// The core takes one word per clock cycle unless stalled, through an input
// register, one pass of parity logic, and a result register. Back-pressure
// on the result side stalls both stages, while a waiting result does not
// stop the next word entering an empty input register. A command of encode
// places the data bits at the non-power-of-two positions and fills the
// parity positions; a command of check returns the syndrome, i.e. the
// 1-based error position, 0 meaning no error. The user writes the data
// length (1 to 26, reset 4) on the configuration port only while the core
// is idle, not enforced by the core; it takes effect from the next cycle.
`include "hamming_encode_check_core_assert.svh"

module hamming_encode_check_core #(
    parameter int MAX_CODE_BITS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hec_pkg::POS_BITS-1:0]   cfg_data,
    // Input words
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_command,
    input  logic [hec_pkg::DATA_BITS-1:0]  s_data_word,
    input  logic [hec_pkg::CODE_BITS-1:0]  s_received_word,
    // Result words
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [hec_pkg::CODE_BITS-1:0]  m_code_word,
    output logic [hec_pkg::POS_BITS-1:0]   m_error_position,
    output logic [hec_pkg::POS_BITS-1:0]   m_code_length
);
    import hec_pkg::*;

    cfg_t cfg;

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic                 command_reg;
    logic [DATA_BITS-1:0] data_word_reg;
    logic [CODE_BITS-1:0] received_word_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [CODE_BITS-1:0] code_word_reg;
    logic [POS_BITS-1:0]  error_position_reg;
    logic [POS_BITS-1:0]  code_length_reg;

    logic                 in_take;
    logic                 out_load;
    logic [CODE_BITS-1:0] code_word;
    logic [POS_BITS-1:0]  error_position;
    logic [POS_BITS-1:0]  code_length;

    assign cfg_ready = 1'b1;

    hec_cfg #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Handshake: the result register loads when it is empty or being read,
    // and the input register takes a word when it is empty or moving on.
    assign out_load = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || out_load;
    assign in_take  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (out_load) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (in_take) begin
            command_reg       <= s_command;
            data_word_reg     <= s_data_word;
            received_word_reg <= s_received_word;
        end
    end

    hec_code_unit u_code_unit (
        .command        (command_reg),
        .data_word      (data_word_reg),
        .received_word  (received_word_reg),
        .cfg            (cfg),
        .code_word      (code_word),
        .error_position (error_position),
        .code_length    (code_length)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            code_word_reg      <= code_word;
            error_position_reg <= error_position;
            code_length_reg    <= code_length;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_code_word      = code_word_reg;
    assign m_error_position = error_position_reg;
    assign m_code_length    = code_length_reg;

    // An encode result never carries a syndrome, a check result never a codeword.
    `HEC_ASSERT_IMPLY(a_result_exclusive, aclk, aresetn, out_valid_reg,
        (code_word_reg == '0) || (error_position_reg == '0),
        "result carries both a codeword and a syndrome")

    // An encoded word has no bits beyond the configured code length.
    `HEC_ASSERT_IMPLY(a_code_within_len, aclk, aresetn, out_valid_reg,
        (code_word_reg & ~cfg.code_mask) == '0,
        "codeword bits set beyond the code length")

    // A word held in the input register is not dropped while the output stalls.
    `HEC_ASSERT_NEXT(a_input_kept, aclk, aresetn, in_valid_reg && !out_load,
        in_valid_reg, "input word lost while stalled")

endmodule

[verif/hamming_encode_check_core_tb.sv]
// ---------------------------------------------------------------------------
// Hamming encode/check core testbench
// Drives encode and check words through the core at several data lengths,
// predicts each result with an independent Hamming coder and compares the
// result words in order, under varied sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
module hamming_encode_check_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import hec_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int CODE_LIMIT    = 31;
    localparam int PHASE_WORDS   = 105;
    localparam int RANDOM_PHASES = 10;
    localparam int HOLD_CYCLES   = 300;
    localparam int REPORT_LIMIT  = 10;

    // Ways in which the two sides idle during a phase.
    typedef enum int {
        GAPS_NONE,
        GAPS_SENDER,
        GAPS_RECEIVER,
        GAPS_BOTH,
        GAPS_PRESSURE
    } gap_mode_t;

    typedef struct packed {
        logic                 command;
        logic [DATA_BITS-1:0] data_word;
        logic [CODE_BITS-1:0] received_word;
    } coder_word_t;

    typedef struct packed {
        logic [CODE_BITS-1:0] code_word;
        logic [POS_BITS-1:0]  error_position;
        logic [POS_BITS-1:0]  code_length;
    } coder_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [POS_BITS-1:0]  cfg_data  = '0;

    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic                 s_command       = CMD_ENCODE;
    logic [DATA_BITS-1:0] s_data_word     = '0;
    logic [CODE_BITS-1:0] s_received_word = '0;

    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [CODE_BITS-1:0] m_code_word;
    logic [POS_BITS-1:0]  m_error_position;
    logic [POS_BITS-1:0]  m_code_length;

    coder_word_t   pending_words[$];
    coder_result_t expected_results[$];

    logic [POS_BITS-1:0] length_reg = DATA_LEN_RESET;
    gap_mode_t           gap_mode   = GAPS_NONE;
    logic                s_fire     = 1'b0;
    int                  held_cycles = 0;
    int                  cycle_count = 0;
    int                  error_count = 0;
    int                  encode_count = 0;
    int                  check_count  = 0;
    int                  flagged_count = 0;
    int                  length_writes = 0;

    hamming_encode_check_core uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_data_word      (s_data_word),
        .s_received_word  (s_received_word),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_code_word      (m_code_word),
        .m_error_position (m_error_position),
        .m_code_length    (m_code_length)
    );

    always begin
        #5 aclk = ~aclk;
    end

    // Smallest parity count p with n <= 2^p - p - 1.
    function automatic int check_bits(int n);
        int p;
        p = 1;
        while (p < 6 && n > (1 << p) - p - 1) begin
            p++;
        end
        return p;
    endfunction

    // Data length actually used for a register value.
    function automatic int usable_bits(logic [POS_BITS-1:0] reg_val);
        int n;
        n = int'(reg_val);
        if (n < 1) begin
            n = 1;
        end
        if (n > DATA_BITS) begin
            n = DATA_BITS;
        end
        while (n > 1 && n + check_bits(n) > CODE_LIMIT) begin
            n--;
        end
        return n;
    endfunction

    function automatic int word_length(logic [POS_BITS-1:0] reg_val);
        int n;
        n = usable_bits(reg_val);
        return n + check_bits(n);
    endfunction

    // XOR of the position numbers of all set bits up to the code length.
    function automatic logic [POS_BITS-1:0] position_syndrome(logic [CODE_BITS-1:0] w,
                                                               int len);
        logic [POS_BITS-1:0] s;
        s = '0;
        for (int pos = 1; pos <= len && pos <= CODE_BITS; pos++) begin
            if (w[pos-1]) begin
                s ^= POS_BITS'(pos);
            end
        end
        return s;
    endfunction

    // Expected result of one word at the given register value.
    function automatic coder_result_t hamming_result(coder_word_t w,
                                                     logic [POS_BITS-1:0] reg_val);
        coder_result_t r;
        int n, p, len, j;
        logic [POS_BITS-1:0] s;
        n   = usable_bits(reg_val);
        p   = check_bits(n);
        len = n + p;
        r   = '0;
        r.code_length = POS_BITS'(len);
        if (w.command == CMD_ENCODE) begin
            j = 0;
            for (int pos = 1; pos <= len; pos++) begin
                if ((pos & (pos - 1)) != 0) begin
                    if (j < DATA_BITS) begin
                        r.code_word[pos-1] = w.data_word[j];
                    end
                    j++;
                end
            end
            // Parity positions are still clear, so the syndrome gives them.
            s = position_syndrome(r.code_word, len);
            for (int i = 0; i < p && i < POS_BITS; i++) begin
                if (s[i]) begin
                    r.code_word[(1 << i) - 1] = 1'b1;
                end
            end
        end else begin
            r.error_position = position_syndrome(w.received_word, len);
        end
        return r;
    endfunction

    function automatic logic sender_idles(gap_mode_t mode);
        int roll;
        roll = $urandom_range(0, 99);
        return (mode == GAPS_SENDER && roll < 74) || (mode == GAPS_BOTH && roll < 11);
    endfunction

    // Sender: offers the next pending word, holding it until it is taken.
    always @(negedge aclk) begin : drive_words
        coder_word_t w;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_fire) begin
            // Word still waiting for the core.
        end else if (pending_words.size() != 0 && !sender_idles(gap_mode)) begin
            w = pending_words.pop_front();
            s_valid         <= 1'b1;
            s_command       <= w.command;
            s_data_word     <= w.data_word;
            s_received_word <= w.received_word;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, and one long hold-off in the first pressure phase.
    always @(negedge aclk) begin : drive_ready
        int roll;
        roll = $urandom_range(0, 99);
        if (gap_mode == GAPS_PRESSURE && held_cycles < HOLD_CYCLES) begin
            held_cycles++;
            m_ready <= 1'b0;
        end else if (gap_mode == GAPS_RECEIVER) begin
            m_ready <= (roll >= 74);
        end else if (gap_mode == GAPS_BOTH) begin
            m_ready <= (roll >= 11);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: tracks the register, predicts accepted words, checks results.
    always @(posedge aclk) begin : watch_ports
        coder_word_t   w;
        coder_result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end else begin
            s_fire <= s_valid && s_ready;
            if (aresetn) begin
                if (cfg_valid && cfg_ready) begin
                    length_reg = cfg_data;
                end
                if (s_valid && s_ready) begin
                    w.command       = s_command;
                    w.data_word     = s_data_word;
                    w.received_word = s_received_word;
                    expected_results.push_back(hamming_result(w, length_reg));
                    if (s_command == CMD_ENCODE) begin
                        encode_count++;
                    end else begin
                        check_count++;
                    end
                end
                if (m_valid && m_ready) begin
                    if (expected_results.size() == 0) begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT) begin
                            $display("tb: unexpected result word %h/%0d/%0d",
                                     m_code_word, m_error_position, m_code_length);
                        end
                    end else begin
                        want = expected_results.pop_front();
                        if (m_error_position != 0) begin
                            flagged_count++;
                        end
                        if (m_code_word !== want.code_word
                            || m_error_position !== want.error_position
                            || m_code_length !== want.code_length) begin
                            error_count++;
                            if (error_count <= REPORT_LIMIT) begin
                                $display("tb: mismatch code %h/%h pos %0d/%0d len %0d/%0d",
                                         want.code_word, m_code_word,
                                         want.error_position, m_error_position,
                                         want.code_length, m_code_length);
                            end
                        end
                    end
                end
            end
        end
    end

    task automatic add_word(logic cmd, logic [DATA_BITS-1:0] data,
                            logic [CODE_BITS-1:0] recv);
        coder_word_t w;
        w.command       = cmd;
        w.data_word     = data;
        w.received_word = recv;
        pending_words.push_back(w);
    endtask

    // Valid codeword for the current length, as the core should encode it.
    function automatic logic [CODE_BITS-1:0] clean_code(logic [DATA_BITS-1:0] data);
        coder_word_t w;
        coder_result_t r;
        w = '0;
        w.command   = CMD_ENCODE;
        w.data_word = data;
        r = hamming_result(w, length_reg);
        return r.code_word;
    endfunction

    task automatic add_random_word();
        int kind, len, flips;
        logic [CODE_BITS-1:0] cw;
        kind = $urandom_range(0, 99);
        len  = word_length(length_reg);
        if (kind < 45) begin
            add_word(CMD_ENCODE, DATA_BITS'($urandom), CODE_BITS'($urandom));
        end else if (kind < 85) begin
            // Well-formed codeword with up to two flipped bits, sometimes with stray bits above the code length.
            cw    = clean_code(DATA_BITS'($urandom));
            flips = $urandom_range(0, 2);
            for (int k = 0; k < flips; k++) begin
                cw[$urandom_range(0, len - 1)] ^= 1'b1;
            end
            if ($urandom_range(0, 3) == 0) begin
                cw |= CODE_BITS'($urandom) & ~((CODE_BITS'(1) << len) - 1);
            end
            add_word(CMD_CHECK, DATA_BITS'($urandom), cw);
        end else begin
            add_word(CMD_CHECK, DATA_BITS'($urandom), CODE_BITS'($urandom));
        end
    endtask

    task automatic wait_quiet();
        while (pending_words.size() != 0 || s_valid || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_length(logic [POS_BITS-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do begin
            @(posedge aclk);
        end while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
        cfg_valid <= 1'b0;
        length_writes++;
    endtask

    // Stimulus sequence.
    initial begin : run_test
        logic [CODE_BITS-1:0] cw;
        logic [POS_BITS-1:0]  lengths[RANDOM_PHASES];
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset length of four: extremes, a known word, every single error and one double error.
        add_word(CMD_ENCODE, '0, '0);
        add_word(CMD_ENCODE, '1, '1);
        add_word(CMD_ENCODE, DATA_BITS'(4'b1011), '0);
        add_word(CMD_CHECK, '1, '0);
        add_word(CMD_CHECK, '0, '1);
        cw = clean_code(DATA_BITS'(4'b1011));
        for (int pos = 0; pos < 7; pos++) begin
            add_word(CMD_CHECK, '0, cw ^ (CODE_BITS'(1) << pos));
        end
        add_word(CMD_CHECK, '0, cw ^ CODE_BITS'(7'b0100100));
        wait_quiet();

        // Longest code: all bits set gives a zero syndrome, top bit alone 31.
        write_length(DATA_LEN_MAX);
        add_word(CMD_ENCODE, '1, '0);
        add_word(CMD_CHECK, '0, '1);
        add_word(CMD_CHECK, '0, CODE_BITS'(1) << (CODE_BITS - 1));
        wait_quiet();

        // Zero counts as one data bit; values above the range count as 26.
        write_length('0);
        add_word(CMD_ENCODE, '1, '0);
        add_word(CMD_CHECK, '0, '1);
        wait_quiet();
        write_length('1);
        add_word(CMD_ENCODE, DATA_BITS'(26'h2AAAAAA), '0);
        add_word(CMD_CHECK, '0, CODE_BITS'(31'h55555555));
        wait_quiet();

        // Random phases, each at a written length and one of the idling patterns in turn.
        lengths = '{5'd1, 5'd26, 5'd0, 5'd31, 5'd27, 5'd11, 5'd12, 5'd5, 5'd2, 5'd4};
        lengths[RANDOM_PHASES - 1] = POS_BITS'($urandom);
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            write_length(lengths[ph]);
            gap_mode = gap_mode_t'(ph % 5);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                add_random_word();
            end
            wait_quiet();
        end
        gap_mode = GAPS_NONE;
        repeat (6) @(posedge aclk);

        $display("tb: %0d encode and %0d check words over %0d length writes;",
                 encode_count, check_count, length_writes);
        $display("tb: %0d results flagged a nonzero syndrome", flagged_count);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: %0d errors", error_count);
            $display("tb: failure");
        end
        $finish;
    end

endmodule
